// ===== rtl/core/lsf_pkg.sv =====
// Shared types, widths and the fixed-point log2 helper of the log spectral flux block.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package lsf_pkg;

  // Storage and field widths
  localparam int MAX_BINS = 512;
  localparam int POS_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam int MAG_W    = 16;
  localparam int CFG_W    = 10;
  localparam int EXP_W    = 5;
  localparam int FRAC_W   = 10;
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int SQ_W     = 29;
  localparam int SUM_W    = SQ_W + POS_W;
  localparam int DEN_W    = SQ_W + CNT_W;
  localparam int FLUX_W   = 16;
  localparam int QCNT_W   = $clog2(FLUX_W);

  localparam logic [CFG_W-1:0] NUM_BINS_RST = CFG_W'(512);
  localparam logic [CFG_W-1:0] MIN_BINS     = CFG_W'(2);

  // One finished frame, handed from the accumulator to the divider
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  largest;
    logic [CNT_W-1:0] n;
  } frame_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_CHECK,
    D_DIV,
    D_HOLD
  } div_state_t;

  // log2(mag + 1) in unsigned Q5.10: exponent above, truncated mantissa below
  function automatic logic [LOG_W-1:0] log2_q10(input logic [MAG_W-1:0] mag);
    logic [MAG_W:0]          v;
    logic [MAG_W:0]          r;
    logic [EXP_W-1:0]        e;
    logic [MAG_W+FRAC_W-1:0] t;
    logic [FRAC_W-1:0]       f;
    v = {1'b0, mag} + (MAG_W + 1)'(1);
    e = '0;
    for (int i = 0; i <= MAG_W; i++) begin
      if (v[i]) begin
        e = EXP_W'(i);
      end
    end
    r    = v;
    r[e] = 1'b0;
    if (e < EXP_W'(FRAC_W)) begin
      t = (MAG_W + FRAC_W)'(r) << (EXP_W'(FRAC_W) - e);
    end else begin
      t = (MAG_W + FRAC_W)'(r) >> (e - EXP_W'(FRAC_W));
    end
    f = t[FRAC_W-1:0];
    return {e, f};
  endfunction

endpackage

// ===== rtl/core/lsf_bin_path.sv =====
// Per-bin datapath: previous-frame memory, log difference, square and frame accumulation.
// Depends on lsf_pkg; feeds lsf_div with one frame_t per closed frame.
`timescale 1ns / 1ps

module lsf_bin_path (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lsf_pkg::MAG_W-1:0]  bin_value,
  input  logic [lsf_pkg::CNT_W-1:0]  bin_count,
  input  logic                       div_busy,
  output lsf_pkg::frame_t            frame
);

  logic [lsf_pkg::MAG_W-1:0] mem [lsf_pkg::MAX_BINS];
  logic [lsf_pkg::MAG_W-1:0] rd_data;

  logic [lsf_pkg::POS_W-1:0] pos;
  logic [lsf_pkg::POS_W-1:0] hwm;
  logic                      in_last;
  logic                      accept;
  logic                      close_busy;

  // Stage 1: memory read returns
  logic                      s1_valid;
  logic [lsf_pkg::MAG_W-1:0] s1_cur;
  logic [lsf_pkg::POS_W-1:0] s1_pos;
  logic                      s1_skip;
  logic                      s1_last;
  logic                      s1_prev_ok;
  logic [lsf_pkg::CNT_W-1:0] s1_n;

  // Stage 2: log difference
  logic                      s2_valid;
  logic [lsf_pkg::LOG_W-1:0] s2_diff;
  logic                      s2_last;
  logic [lsf_pkg::CNT_W-1:0] s2_n;

  // Stage 3: square
  logic                      s3_valid;
  logic [lsf_pkg::SQ_W-1:0]  s3_sq;
  logic                      s3_last;
  logic [lsf_pkg::CNT_W-1:0] s3_n;

  logic [lsf_pkg::SUM_W-1:0] sum;
  logic [lsf_pkg::SQ_W-1:0]  largest;
  logic [lsf_pkg::SUM_W-1:0] sum_next;
  logic [lsf_pkg::SQ_W-1:0]  largest_next;

  logic [lsf_pkg::MAG_W-1:0]   prev_mag;
  logic [lsf_pkg::LOG_W-1:0]   log_cur;
  logic [lsf_pkg::LOG_W-1:0]   log_prev;
  logic [lsf_pkg::LOG_W-1:0]   diff;
  logic [2*lsf_pkg::LOG_W-1:0] sq_full;

  assign in_last    = (lsf_pkg::CNT_W'(pos) + lsf_pkg::CNT_W'(1)) >= bin_count;
  assign close_busy = (s1_valid && s1_last) || (s2_valid && s2_last) ||
                      (s3_valid && s3_last) || div_busy;
  // hold a frame-closing bin until the previous frame has left the divider
  assign in_stall   = in_last && close_busy;
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    rd_data <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_skip) begin
      mem[s1_pos] <= s1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hwm      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        pos <= in_last ? '0 : pos + lsf_pkg::POS_W'(1);
        if (pos > hwm) begin
          hwm <= pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur     <= bin_value;
      s1_pos     <= pos;
      s1_skip    <= (pos == '0);
      s1_last    <= in_last;
      s1_prev_ok <= (pos <= hwm);
      s1_n       <= bin_count;
    end
  end

  always_comb begin
    prev_mag = s1_prev_ok ? rd_data : '0;
    log_cur  = lsf_pkg::log2_q10(s1_cur);
    log_prev = lsf_pkg::log2_q10(prev_mag);
    if (s1_skip) begin
      diff = '0;
    end else if (log_cur >= log_prev) begin
      diff = log_cur - log_prev;
    end else begin
      diff = log_prev - log_cur;
    end
    sq_full = (2*lsf_pkg::LOG_W)'(s2_diff) * (2*lsf_pkg::LOG_W)'(s2_diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_diff <= diff;
    s2_last <= s1_last;
    s2_n    <= s1_n;
    s3_sq   <= sq_full[lsf_pkg::SQ_W-1:0];
    s3_last <= s2_last;
    s3_n    <= s2_n;
  end

  always_comb begin
    sum_next     = sum + lsf_pkg::SUM_W'(s3_sq);
    largest_next = (s3_sq > largest) ? s3_sq : largest;
    frame.valid   = s3_valid && s3_last;
    frame.sum     = sum_next;
    frame.largest = largest_next;
    frame.n       = s3_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      largest <= '0;
    end else if (s3_valid) begin
      if (s3_last) begin
        sum     <= '0;
        largest <= '0;
      end else begin
        sum     <= sum_next;
        largest <= largest_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_close: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1_valid && s1_last, s2_valid && s2_last, s3_valid && s3_last, div_busy}))
    else $error("more than one frame close in flight");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_last) |=> (sum == '0 && largest == '0))
    else $error("accumulators not cleared after frame close");
`endif

endmodule

// ===== rtl/core/lsf_div.sv =====
// Frame normalizer: forms largest * n, divides sum * 2^16 by it bit by bit, holds the result.
// Depends on lsf_pkg; takes frame_t from lsf_bin_path and drives the result channel.
`timescale 1ns / 1ps

module lsf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  lsf_pkg::frame_t            frame,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lsf_pkg::FLUX_W-1:0] flux
);

  lsf_pkg::div_state_t state;
  lsf_pkg::div_state_t state_next;

  logic [lsf_pkg::SUM_W-1:0]  sum;
  logic [lsf_pkg::SQ_W-1:0]   largest;
  logic [lsf_pkg::CNT_W-1:0]  n;
  logic [lsf_pkg::DEN_W-1:0]  den;
  logic [lsf_pkg::DEN_W-1:0]  rem;
  logic [lsf_pkg::DEN_W:0]    rem2;
  logic [lsf_pkg::FLUX_W-1:0] q;
  logic [lsf_pkg::QCNT_W-1:0] step;
  logic                       sum_ge;
  logic                       rem_ge;
  logic [lsf_pkg::FLUX_W-1:0] result;
  logic                       result_valid;
  logic                       result_load;

  assign sum_ge    = lsf_pkg::DEN_W'(sum) >= den;
  assign rem2      = {rem, 1'b0};
  assign rem_ge    = rem2 >= {1'b0, den};
  assign out_valid = result_valid;
  assign flux      = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsf_pkg::D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    result_load = 1'b0;
    busy        = 1'b1;
    case (state)
      lsf_pkg::D_IDLE: begin
        busy = 1'b0;
        if (frame.valid) begin
          state_next = lsf_pkg::D_MUL;
        end
      end
      lsf_pkg::D_MUL: begin
        state_next = lsf_pkg::D_CHECK;
      end
      lsf_pkg::D_CHECK: begin
        if (largest == '0 || sum_ge) begin
          state_next = lsf_pkg::D_HOLD;
        end else begin
          state_next = lsf_pkg::D_DIV;
        end
      end
      lsf_pkg::D_DIV: begin
        if (step == lsf_pkg::QCNT_W'(lsf_pkg::FLUX_W - 1)) begin
          state_next = lsf_pkg::D_HOLD;
        end
      end
      lsf_pkg::D_HOLD: begin
        // hand the quotient over once the output register is free or draining
        if (!result_valid || !out_stall) begin
          result_load = 1'b1;
          state_next  = lsf_pkg::D_IDLE;
        end
      end
      default: begin
        state_next = lsf_pkg::D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      lsf_pkg::D_IDLE: begin
        if (frame.valid) begin
          sum     <= frame.sum;
          largest <= frame.largest;
          n       <= frame.n;
        end
      end
      lsf_pkg::D_MUL: begin
        den <= lsf_pkg::DEN_W'(largest) * lsf_pkg::DEN_W'(n);
      end
      lsf_pkg::D_CHECK: begin
        rem  <= lsf_pkg::DEN_W'(sum);
        step <= '0;
        // flat frame gives zero; a ratio of one or more saturates
        if (largest == '0) begin
          q <= '0;
        end else if (sum_ge) begin
          q <= '1;
        end else begin
          q <= '0;
        end
      end
      lsf_pkg::D_DIV: begin
        step <= step + lsf_pkg::QCNT_W'(1);
        if (rem_ge) begin
          rem <= lsf_pkg::DEN_W'(rem2 - {1'b0, den});
          q   <= {q[lsf_pkg::FLUX_W-2:0], 1'b1};
        end else begin
          rem <= rem2[lsf_pkg::DEN_W-1:0];
          q   <= {q[lsf_pkg::FLUX_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!out_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= q;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> (state == lsf_pkg::D_IDLE))
    else $error("frame arrived while divider busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lsf_pkg::D_DIV) |-> (rem < den))
    else $error("partial remainder not below divisor");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(flux)))
    else $error("stalled result changed or dropped");
`endif

endmodule

// ===== rtl/core/log_spectral_flux.sv =====
// Top level of the normalized log spectral flux block: configuration register and wiring.
// Depends on lsf_pkg, lsf_bin_path and lsf_div.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / bin_value): one spectral magnitude per transfer,
//   num_bins bins per frame, bin zero first. Bin zero only advances the position.
//   Output channel (out_valid / out_stall / flux): one unsigned Q0.16 transfer per frame,
//   sum of squared log2 differences over (largest square * num_bins), zero for a flat frame.
//   Config channel (cfg_valid / cfg_ready / num_bins): always ready; write only while idle.
//   num_bins outside 2..512 is clamped to that range.
// Throughput: one bin per cycle. A frame-closing bin is held with in_stall until the
// shared divider is free; a finished result moves to the output register first.
// Path: from the closing bin's transfer to out_valid, the result passes the bin pipeline
// stages, capture, multiply, range check, 16 restoring divide steps, output register;
// flat or saturating frames skip the divide steps.
// Reset: synchronous, active high. Clears the position, the accumulators and the divider,
// and sets num_bins to 512. The previous-frame memory is not swept: a high-water mark of
// written bins makes entries never written read as zero, so no clearing pass is needed.
// Receiver stall: the result holds in the output register while the divider takes the
// next frame; that quotient waits in the divider, and only then closing bins back up.
module log_spectral_flux (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lsf_pkg::MAG_W-1:0]  bin_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lsf_pkg::FLUX_W-1:0] flux,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lsf_pkg::CFG_W-1:0]  num_bins
);

  logic [lsf_pkg::CFG_W-1:0] num_bins_reg;
  logic [lsf_pkg::CNT_W-1:0] bin_count;
  logic                      div_busy;
  lsf_pkg::frame_t           frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins_reg <= lsf_pkg::NUM_BINS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_bins_reg <= num_bins;
    end
  end

  // clamp the bin count to the minimum of two and to what the memory holds
  always_comb begin
    if (num_bins_reg < lsf_pkg::MIN_BINS) begin
      bin_count = lsf_pkg::CNT_W'(lsf_pkg::MIN_BINS);
    end else if (32'(num_bins_reg) > 32'(lsf_pkg::MAX_BINS)) begin
      bin_count = lsf_pkg::CNT_W'(lsf_pkg::MAX_BINS);
    end else begin
      bin_count = lsf_pkg::CNT_W'(num_bins_reg);
    end
  end

  lsf_bin_path u_bin_path (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .bin_value (bin_value),
    .bin_count (bin_count),
    .div_busy  (div_busy),
    .frame     (frame)
  );

  lsf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .busy      (div_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flux      (flux)
  );

endmodule
